// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the datapath modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pse_pkg.sv =====
// Types and constants for the PCM sample edit datapath
package pse_pkg;

  typedef enum logic [2:0] {
    OP_FLIP   = 3'd0,
    OP_WIDEN  = 3'd1,
    OP_NARROW = 3'd2,
    OP_SUB    = 3'd3,
    OP_AMP    = 3'd4,
    OP_DELTA  = 3'd5,
    OP_INVERT = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    REG_OPERATION = 2'd0,
    REG_WIDE      = 2'd1,
    REG_GAIN      = 2'd2,
    REG_DC_OFFSET = 2'd3
  } cfg_idx_t;

  localparam int unsigned GAIN_DIV    = 100;
  localparam int unsigned AMP_SHIFT   = 29;
  localparam int unsigned AMP_DIRECT_W = 22;
  localparam int unsigned AMP_RECIP_W = 23;
  localparam logic [AMP_RECIP_W-1:0] AMP_RECIP =
    AMP_RECIP_W'(((64'd1 << AMP_SHIFT) + GAIN_DIV - 1) / GAIN_DIV);

  localparam logic [15:0] GAIN_RESET = 16'(GAIN_DIV);
  localparam logic signed [15:0] MARK_LOW_RESET  = 16'sh7FFF;
  localparam logic signed [15:0] MARK_HIGH_RESET = 16'sh8000;

  typedef struct packed {
    op_t                op;
    logic               wide;
    logic [15:0]        gain;
    logic signed [15:0] dc;
  } cfg_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        first;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic               amp;
    logic               neg;
    logic [30:0]        prod;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic signed [15:0] centre;
  } trk_req_t;

endpackage

// ===== hw/rtl/pcm_sample_edit_datapath.sv =====
// Top level of the PCM sample edit datapath: config registers and stage chain
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_sample_in, in_first_sample
//  out_    | output    | out_valid/out_stall| out_sample_out, out_running_min/max,
//          |           |                    | out_centre_offset
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request a cycle unless stalled; each passes the input register, the
// tracking/gain product, divide-by-100 and saturation into the result register.
// Each stage holds its request while the next one stalls and refills bubbles.
// Sync active-low reset clears valids, marks, delta sum and config registers.
module pcm_sample_edit_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  input  logic               in_first_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out,
  output logic signed [15:0] out_running_min,
  output logic signed [15:0] out_running_max,
  output logic signed [15:0] out_centre_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  pse_pkg::cfg_t     cfg_r;
  pse_pkg::in_req_t  in_d, s0_d;
  pse_pkg::trk_req_t s1_d;
  logic              s0_valid, s0_stall, s1_valid, s1_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op   <= pse_pkg::OP_FLIP;
      cfg_r.wide <= 1'b0;
      cfg_r.gain <= pse_pkg::GAIN_RESET;
      cfg_r.dc   <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pse_pkg::cfg_idx_t'(cfg_index))
        pse_pkg::REG_OPERATION: cfg_r.op   <= pse_pkg::op_t'(cfg_data[2:0]);
        pse_pkg::REG_WIDE:      cfg_r.wide <= cfg_data[0];
        pse_pkg::REG_GAIN:      cfg_r.gain <= cfg_data;
        pse_pkg::REG_DC_OFFSET: cfg_r.dc   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_d.sample = in_sample_in;
  assign in_d.first  = in_first_sample;

  pse_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_d      (in_d),
    .out_valid (s0_valid),
    .out_stall (s0_stall),
    .out_d     (s0_d)
  );

  pse_trk_stage u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (s0_valid),
    .in_stall  (s0_stall),
    .in_d      (s0_d),
    .out_valid (s1_valid),
    .out_stall (s1_stall),
    .out_d     (s1_d)
  );

  pse_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .wide              (cfg_r.wide),
    .in_valid          (s1_valid),
    .in_stall          (s1_stall),
    .in_d              (s1_d),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_out    (out_sample_out),
    .out_running_min   (out_running_min),
    .out_running_max   (out_running_max),
    .out_centre_offset (out_centre_offset)
  );

endmodule

// ===== hw/rtl/pse_in_stage.sv =====
// Input register stage
module pse_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pse_pkg::in_req_t in_d,
  output logic            out_valid,
  input  logic            out_stall,
  output pse_pkg::in_req_t out_d
);

  logic            valid_r;
  pse_pkg::in_req_t d_r;
  logic            en;

  assign en       = !valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      d_r <= in_d;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

// ===== hw/rtl/pse_trk_stage.sv =====
// Tracking stage: min/max, delta sum, simple operations and gain product
`include "assert_macros.svh"
module pse_trk_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  pse_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  pse_pkg::in_req_t in_d,
  output logic             out_valid,
  input  logic             out_stall,
  output pse_pkg::trk_req_t out_d
);

  logic               valid_r;
  pse_pkg::trk_req_t  d_r;
  pse_pkg::trk_req_t  d_nxt;
  logic signed [15:0] low_r, low_nxt;
  logic signed [15:0] high_r, high_nxt;
  logic signed [15:0] delta_r, delta_nxt;
  logic signed [15:0] x;
  logic signed [15:0] base;
  logic signed [15:0] y_raw;
  logic signed [15:0] dsum;
  logic signed [16:0] csum;
  logic [15:0]        absx;
  logic [31:0]        prod;
  logic               en;
  logic               load;

  assign en       = !valid_r || !out_stall;
  assign in_stall = !en;
  assign load     = en && in_valid;

  assign x = cfg.wide ? in_d.sample : {{8{in_d.sample[7]}}, in_d.sample[7:0]};

  always_comb begin
    if (in_d.first) begin
      low_nxt  = x;
      high_nxt = x;
    end else begin
      low_nxt  = (x < low_r) ? x : low_r;
      high_nxt = (x > high_r) ? x : high_r;
    end
  end

  assign base = in_d.first ? 16'sd0 : delta_r;
  assign dsum = base + x;
  assign csum = 17'(high_nxt) + 17'(low_nxt) + 17'sd1;

  always_comb begin
    delta_nxt = base;
    y_raw     = x;
    case (cfg.op)
      pse_pkg::OP_FLIP:   y_raw = x ^ (cfg.wide ? 16'h8000 : 16'h0080);
      pse_pkg::OP_WIDEN:  y_raw = cfg.wide ? x : {x[7:0], 8'h00};
      pse_pkg::OP_NARROW: y_raw = cfg.wide ? (x >>> 8) : x;
      pse_pkg::OP_SUB:    y_raw = x - cfg.dc;
      pse_pkg::OP_AMP:    y_raw = 16'sd0;
      pse_pkg::OP_DELTA: begin
        y_raw     = dsum;
        delta_nxt = cfg.wide ? dsum : {{8{dsum[7]}}, dsum[7:0]};
      end
      pse_pkg::OP_INVERT: y_raw = ~x;
      default:            y_raw = x;
    endcase
  end

  assign absx = x[15] ? 16'(-x) : 16'(x);
  assign prod = 32'(absx) * 32'(cfg.gain);

  always_comb begin
    d_nxt.y = y_raw;
    if (!cfg.wide && cfg.op != pse_pkg::OP_WIDEN) begin
      d_nxt.y = {{8{y_raw[7]}}, y_raw[7:0]};
    end
    d_nxt.amp    = (cfg.op == pse_pkg::OP_AMP);
    d_nxt.neg    = x[15];
    d_nxt.prod   = prod[30:0];
    d_nxt.low    = low_nxt;
    d_nxt.high   = high_nxt;
    d_nxt.centre = csum[16:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      low_r   <= pse_pkg::MARK_LOW_RESET;
      high_r  <= pse_pkg::MARK_HIGH_RESET;
      delta_r <= 16'sd0;
    end else begin
      if (en) begin
        valid_r <= in_valid;
      end
      if (load) begin
        low_r   <= low_nxt;
        high_r  <= high_nxt;
        delta_r <= delta_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

  `PSE_ASSERT_NXT(a_first_marks_equal, clk, rst_n, load && in_d.first,
                  low_r == high_r, "restart left min and max apart")
  `PSE_ASSERT_NXT(a_marks_ordered, clk, rst_n, load, low_r <= high_r,
                  "running min above running max")
  `PSE_ASSERT_NXT(a_delta_hold, clk, rst_n,
                  load && !in_d.first && cfg.op != pse_pkg::OP_DELTA,
                  $stable(delta_r), "delta sum moved outside delta decode")

endmodule

// ===== hw/rtl/pse_out_stage.sv =====
// Result stage: divide gain product by 100, saturate, result register
`include "assert_macros.svh"
module pse_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wide,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  pse_pkg::trk_req_t        in_d,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_sample_out,
  output logic signed [15:0]       out_running_min,
  output logic signed [15:0]       out_running_max,
  output logic signed [15:0]       out_centre_offset
);

  localparam int unsigned QM_W = pse_pkg::AMP_DIRECT_W + pse_pkg::AMP_RECIP_W;

  logic                                 valid_r;
  logic signed [15:0]                   sample_r, min_r, max_r, centre_r;
  logic signed [15:0]                   amp_y;
  logic                                 big;
  logic [pse_pkg::AMP_DIRECT_W-1:0]     n_lo;
  logic [QM_W-1:0]                      qm;
  logic [15:0]                          q;
  logic [16:0]                          mag, pos_lim, neg_lim, neg_val;
  logic                                 en;

  assign en       = !valid_r || !out_stall;
  assign in_stall = !en;

  assign big  = |in_d.prod[30:pse_pkg::AMP_DIRECT_W];
  assign n_lo = in_d.prod[pse_pkg::AMP_DIRECT_W-1:0];
  assign qm   = QM_W'(n_lo) * QM_W'(pse_pkg::AMP_RECIP);
  assign q    = qm[pse_pkg::AMP_SHIFT +: 16];
  assign mag  = big ? 17'h0FFFF : {1'b0, q};

  assign pos_lim = wide ? 17'd32767 : 17'd127;
  assign neg_lim = wide ? 17'd32768 : 17'd128;
  assign neg_val = (mag >= neg_lim) ? (17'd0 - neg_lim) : (17'd0 - mag);

  always_comb begin
    if (in_d.neg) begin
      amp_y = neg_val[15:0];
    end else if (mag > pos_lim) begin
      amp_y = pos_lim[15:0];
    end else begin
      amp_y = mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      sample_r <= in_d.amp ? amp_y : in_d.y;
      min_r    <= in_d.low;
      max_r    <= in_d.high;
      centre_r <= in_d.centre;
    end
  end

  assign out_valid         = valid_r;
  assign out_sample_out    = sample_r;
  assign out_running_min   = min_r;
  assign out_running_max   = max_r;
  assign out_centre_offset = centre_r;

  `PSE_ASSERT_IMP(a_amp_in_range, clk, rst_n, in_valid && in_d.amp,
                  $signed(amp_y) >= -32768 && (wide || ($signed(amp_y) <= 127
                  && $signed(amp_y) >= -128)), "gain result outside sample width")
  `PSE_ASSERT_NXT(a_held_on_stall, clk, rst_n, valid_r && out_stall,
                  valid_r && $stable(sample_r) && $stable(centre_r),
                  "result lost while stalled")
  `PSE_ASSERT_IMP(a_zero_gain, clk, rst_n, in_valid && in_d.amp && in_d.prod == 31'd0,
                  amp_y == 16'sd0, "zero product gave a non-zero result")

endmodule

// ===== tb/pcm_sample_edit_datapath_test.sv =====
// Self-checking testbench for the PCM sample edit datapath: directed table, then random phases
module pcm_sample_edit_datapath_test;
  import pse_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam longint PERCENT = 100;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] ctr;
  } edit_result_t;

  typedef struct packed {
    logic [2:0]   op;
    logic         wide;
    logic [15:0]  gain;
    logic [15:0]  dc;
    logic [15:0]  sample;
    logic         first;
    logic         typed;
    edit_result_t want;
  } edit_row_t;

  localparam edit_result_t NO_RESULT = '0;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample_in = '0;
  logic               in_first_sample = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample_out;
  logic signed [15:0] out_running_min;
  logic signed [15:0] out_running_max;
  logic signed [15:0] out_centre_offset;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // shadow copy of the configuration and tracking state
  logic [2:0]         cfg_op = OP_FLIP;
  logic               cfg_wide = 1'b0;
  logic [15:0]        cfg_gain = GAIN_RESET;
  logic signed [15:0] cfg_dc = '0;
  logic signed [15:0] delta_acc = '0;
  logic signed [15:0] low_mark = MARK_LOW_RESET;
  logic signed [15:0] high_mark = MARK_HIGH_RESET;

  edit_result_t pending_results[$];
  edit_result_t oldest;
  edit_row_t    directed_rows [N_ROWS];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;

  pcm_sample_edit_datapath dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [15:0] to_width(logic [15:0] v);
    return cfg_wide ? v : {{8{v[7]}}, v[7:0]};
  endfunction

  function automatic edit_result_t predict_edit(logic [15:0] raw, logic restart);
    edit_result_t       r;
    logic signed [15:0] x;
    longint             prod;
    longint             lim;
    int                 ctr;
    x = to_width(raw);
    if (restart) begin
      low_mark = x;
      high_mark = x;
      delta_acc = '0;
    end else begin
      if (x < low_mark) low_mark = x;
      if (x > high_mark) high_mark = x;
    end
    case (cfg_op)
      OP_FLIP:   r.y = cfg_wide ? x ^ 16'h8000 : to_width(x ^ 16'h0080);
      OP_WIDEN:  r.y = cfg_wide ? x : x <<< 8;
      OP_NARROW: r.y = cfg_wide ? x >>> 8 : x;
      OP_SUB:    r.y = to_width(x - cfg_dc);
      OP_AMP: begin
        prod = longint'(x) * longint'(cfg_gain) / PERCENT;
        lim = cfg_wide ? 32767 : 127;
        if (prod > lim) prod = lim;
        if (prod < -lim - 1) prod = -lim - 1;
        r.y = 16'(prod);
      end
      OP_DELTA: begin
        delta_acc = to_width(to_width(delta_acc) + x);
        r.y = delta_acc;
      end
      OP_INVERT: r.y = to_width(~x);
      default:   r.y = x;
    endcase
    ctr = (int'(high_mark) + int'(low_mark) + 1) >>> 1;
    r.lo = low_mark;
    r.hi = high_mark;
    r.ctr = 16'(ctr);
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OPERATION: cfg_op = data[2:0];
      REG_WIDE:      cfg_wide = data[0];
      REG_GAIN:      cfg_gain = data;
      REG_DC_OFFSET: cfg_dc = data;
    endcase
  endtask

  task automatic configure(logic [2:0] op, logic wide, logic [15:0] gain, logic [15:0] dc);
    write_reg(REG_OPERATION, {13'd0, op});
    write_reg(REG_WIDE, {15'd0, wide});
    write_reg(REG_GAIN, gain);
    write_reg(REG_DC_OFFSET, dc);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(logic [15:0] s, logic f, logic typed, edit_result_t want);
    edit_result_t r;
    in_valid <= 1'b1;
    in_sample_in <= s;
    in_first_sample <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_edit(s, f);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result expected none got %h", $time, out_sample_out);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("sample_out", oldest.y, out_sample_out);
          check_field("running_min", oldest.lo, out_running_min);
          check_field("running_max", oldest.hi, out_running_max);
          check_field("centre_offset", oldest.ctr, out_centre_offset);
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end
  end

  initial begin
    edit_row_t   row;
    logic [2:0]  op;
    logic        wide;
    logic [15:0] gain;
    logic [15:0] dc;
    logic [15:0] s;
    logic        f;
    int          sent;
    int          n;
    logic [15:0] extremes [7];

    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0080, 16'h007F, 16'hFF80};
    directed_rows = '{
      '{OP_FLIP,   1'b0, GAIN_RESET, 16'h0000, 16'h0000, 1'b0, 1'b1,
        '{16'hFF80, 16'h0000, 16'h0000, 16'h0000}},
      '{OP_FLIP,   1'b0, GAIN_RESET, 16'h0000, 16'hAB7F, 1'b0, 1'b1,
        '{16'hFFFF, 16'h0000, 16'h007F, 16'h0040}},
      '{OP_FLIP,   1'b0, GAIN_RESET, 16'h0000, 16'h0080, 1'b0, 1'b1,
        '{16'h0000, 16'hFF80, 16'h007F, 16'h0000}},
      '{OP_FLIP,   1'b1, GAIN_RESET, 16'h0000, 16'h8000, 1'b1, 1'b1,
        '{16'h0000, 16'h8000, 16'h8000, 16'h8000}},
      '{OP_FLIP,   1'b1, GAIN_RESET, 16'h0000, 16'h7FFF, 1'b0, 1'b1,
        '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000}},
      '{OP_WIDEN,  1'b0, GAIN_RESET, 16'h0000, 16'h0080, 1'b1, 1'b1,
        '{16'h8000, 16'hFF80, 16'hFF80, 16'hFF80}},
      '{OP_WIDEN,  1'b0, GAIN_RESET, 16'h0000, 16'h007F, 1'b0, 1'b1,
        '{16'h7F00, 16'hFF80, 16'h007F, 16'h0000}},
      '{OP_WIDEN,  1'b1, GAIN_RESET, 16'h0000, 16'h1234, 1'b1, 1'b1,
        '{16'h1234, 16'h1234, 16'h1234, 16'h1234}},
      '{OP_NARROW, 1'b1, GAIN_RESET, 16'h0000, 16'h8000, 1'b1, 1'b1,
        '{16'hFF80, 16'h8000, 16'h8000, 16'h8000}},
      '{OP_NARROW, 1'b1, GAIN_RESET, 16'h0000, 16'h7FFF, 1'b0, 1'b1,
        '{16'h007F, 16'h8000, 16'h7FFF, 16'h0000}},
      '{OP_NARROW, 1'b0, GAIN_RESET, 16'h0000, 16'h55C3, 1'b1, 1'b1,
        '{16'hFFC3, 16'hFFC3, 16'hFFC3, 16'hFFC3}},
      '{OP_SUB,    1'b1, GAIN_RESET, 16'h7FFF, 16'h8000, 1'b1, 1'b1,
        '{16'h0001, 16'h8000, 16'h8000, 16'h8000}},
      '{OP_SUB,    1'b0, GAIN_RESET, 16'h8000, 16'h007F, 1'b1, 1'b1,
        '{16'h007F, 16'h007F, 16'h007F, 16'h007F}},
      '{OP_SUB,    1'b0, GAIN_RESET, 16'h0001, 16'h0080, 1'b0, 1'b1,
        '{16'h007F, 16'hFF80, 16'h007F, 16'h0000}},
      '{OP_AMP,    1'b1, 16'hFFFF,   16'h0000, 16'h7FFF, 1'b1, 1'b1,
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
      '{OP_AMP,    1'b1, 16'hFFFF,   16'h0000, 16'h8000, 1'b0, 1'b1,
        '{16'h8000, 16'h8000, 16'h7FFF, 16'h0000}},
      '{OP_AMP,    1'b1, 16'h0000,   16'h0000, 16'h1234, 1'b1, 1'b1,
        '{16'h0000, 16'h1234, 16'h1234, 16'h1234}},
      '{OP_AMP,    1'b0, 16'd150,    16'h0000, 16'h00FF, 1'b1, 1'b1,
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
      '{OP_AMP,    1'b0, 16'hFFFF,   16'h0000, 16'h0080, 1'b0, 1'b1,
        '{16'hFF80, 16'hFF80, 16'hFFFF, 16'hFFC0}},
      '{OP_DELTA,  1'b0, GAIN_RESET, 16'h0000, 16'h0070, 1'b1, 1'b1,
        '{16'h0070, 16'h0070, 16'h0070, 16'h0070}},
      '{OP_DELTA,  1'b0, GAIN_RESET, 16'h0000, 16'h0070, 1'b0, 1'b1,
        '{16'hFFE0, 16'h0070, 16'h0070, 16'h0070}},
      '{OP_DELTA,  1'b1, GAIN_RESET, 16'h0000, 16'h7FFF, 1'b0, 1'b0, NO_RESULT},
      '{OP_INVERT, 1'b0, GAIN_RESET, 16'h0000, 16'h0000, 1'b1, 1'b1,
        '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000}},
      '{OP_INVERT, 1'b1, GAIN_RESET, 16'h0000, 16'h8000, 1'b0, 1'b1,
        '{16'h7FFF, 16'h8000, 16'h0000, 16'hC000}},
      '{OP_UNUSED, 1'b1, GAIN_RESET, 16'h0000, 16'hA5A5, 1'b1, 1'b1,
        '{16'hA5A5, 16'hA5A5, 16'hA5A5, 16'hA5A5}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      if (row.op != cfg_op || row.wide != cfg_wide || row.gain != cfg_gain || row.dc != cfg_dc)
      begin
        drain();
        configure(row.op, row.wide, row.gain, row.dc);
      end
      send_sample(row.sample, row.first, row.typed, row.want);
      maybe_idle();
    end

    // random phases, each under a fresh configuration written while drained
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      op = 3'($urandom_range(0, 7));
      wide = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: gain = 16'h0000;
        1: gain = 16'hFFFF;
        2: gain = GAIN_RESET;
        3: gain = 16'($urandom_range(0, 400));
        default: gain = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: dc = 16'h8000;
        1: dc = 16'h7FFF;
        default: dc = 16'($urandom);
      endcase
      drain();
      configure(op, wide, gain, dc);
      n = $urandom_range(10, 60);
      for (int k = 0; k < n; k++) begin
        s = ($urandom_range(0, 7) == 0) ? extremes[$urandom_range(0, 6)] : 16'($urandom);
        f = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
        send_sample(s, f, 1'b0, NO_RESULT);
        maybe_idle();
        sent++;
        calm = (sent >= 500 && sent < 800);
      end
    end

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
